@@ hw/rtl/atr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atr_pkg: shared constants and types for the atan2 approximation pipeline
// Holds default widths, the ratio format, the 0.28 coefficient and the
// per-item side flags that travel down the pipeline with the data.
// ----------------------------------------------------------------------------
package atr_pkg;

    localparam int ATR_INPUT_WIDTH     = 16;
    localparam int ATR_ANGLE_FRAC_BITS = 12;

    // The ratio min/max is unsigned Q1.15, 1.0 inclusive.
    localparam int RATIO_FRAC  = 15;
    localparam int RATIO_WIDTH = RATIO_FRAC + 1;

    // 0.28 in Q0.15.
    localparam int COEF_WIDTH = 14;
    localparam logic [COEF_WIDTH-1:0] COEF_Q15 = 14'd9175;

    // pi with 32 fraction bits.
    localparam longint unsigned PI_Q32 = 64'd13493037705;

    // Flags derived from the signs and magnitudes of one input pair.
    typedef struct packed {
        logic x_zero;
        logic y_zero;
        logic y_neg;
        logic x_neg;
        logic swapped;   // |y| >= |x|: the ratio is x/y
    } side_t;

    // pi * 2^frac, rounded to nearest.
    function automatic longint unsigned pi_fixed(input int frac);
        pi_fixed = ((PI_Q32 << frac) + (64'd1 << 31)) >> 32;
    endfunction

    // (pi/2) * 2^frac, rounded to nearest.
    function automatic longint unsigned half_pi_fixed(input int frac);
        half_pi_fixed = ((PI_Q32 << frac) + (64'd1 << 32)) >> 33;
    endfunction

endpackage

@@ hw/rtl/atr_prep.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atr_prep: magnitude, octant and ratio setup stage
// Takes absolute values, orders them into smaller and larger, and produces
// the leading quotient bit of the ratio (set only when they are equal).
// ----------------------------------------------------------------------------
module atr_prep #(
    parameter int INPUT_WIDTH = atr_pkg::ATR_INPUT_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [INPUT_WIDTH-1:0] in_y,
    input  logic signed [INPUT_WIDTH-1:0] in_x,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [INPUT_WIDTH-1:0]        out_rem,
    output logic [INPUT_WIDTH-1:0]        out_dvs,
    output logic [atr_pkg::RATIO_WIDTH-1:0] out_quot,
    output atr_pkg::side_t                out_side
);

    logic                              valid_reg;
    logic [INPUT_WIDTH-1:0]            rem_reg, dvs_reg;
    logic [atr_pkg::RATIO_WIDTH-1:0]   quot_reg;
    atr_pkg::side_t                    side_reg;

    logic [INPUT_WIDTH-1:0]            ay, ax, small_v, big_v;
    logic [INPUT_WIDTH-1:0]            rem_next;
    logic [atr_pkg::RATIO_WIDTH-1:0]   quot_next;
    atr_pkg::side_t                    side_next;
    logic                              equal_v;

    // Unsigned magnitudes; the most negative input maps to 2^(W-1) exactly.
    always_comb begin
        ay = in_y[INPUT_WIDTH-1] ? (~in_y + 1'b1) : in_y;
        ax = in_x[INPUT_WIDTH-1] ? (~in_x + 1'b1) : in_x;
        side_next.x_zero  = (in_x == '0);
        side_next.y_zero  = (in_y == '0);
        side_next.y_neg   = in_y[INPUT_WIDTH-1];
        side_next.x_neg   = in_x[INPUT_WIDTH-1];
        side_next.swapped = (ay >= ax);
        small_v   = side_next.swapped ? ax : ay;
        big_v     = side_next.swapped ? ay : ax;
        equal_v   = (small_v == big_v);
        rem_next  = equal_v ? '0 : small_v;
        quot_next = {{(atr_pkg::RATIO_WIDTH-1){1'b0}}, equal_v};
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            rem_reg  <= rem_next;
            dvs_reg  <= big_v;
            quot_reg <= quot_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_dvs   = dvs_reg;
    assign out_quot  = quot_reg;
    assign out_side  = side_reg;

endmodule

@@ hw/rtl/atr_div_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atr_div_step: one registered restoring division step
// Shifts the partial remainder left, subtracts the divisor when it fits and
// shifts the resulting quotient bit in.
// ----------------------------------------------------------------------------
module atr_div_step #(
    parameter int DW = 16,
    parameter int QW = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [DW-1:0]  in_rem,
    input  logic [DW-1:0]  in_dvs,
    input  logic [QW-1:0]  in_quot,
    input  atr_pkg::side_t in_side,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [DW-1:0]  out_rem,
    output logic [DW-1:0]  out_dvs,
    output logic [QW-1:0]  out_quot,
    output atr_pkg::side_t out_side
);

    logic           valid_reg;
    logic [DW-1:0]  rem_reg, dvs_reg;
    logic [QW-1:0]  quot_reg;
    atr_pkg::side_t side_reg;

    logic [DW:0]    trial, diff;
    logic           fits;
    logic [DW-1:0]  rem_next;
    logic [QW-1:0]  quot_next;

    always_comb begin
        trial     = {in_rem, 1'b0};
        diff      = trial - {1'b0, in_dvs};
        fits      = (trial >= {1'b0, in_dvs});
        rem_next  = fits ? diff[DW-1:0] : trial[DW-1:0];
        quot_next = {in_quot[QW-2:0], fits};
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            rem_reg  <= rem_next;
            dvs_reg  <= in_dvs;
            quot_reg <= quot_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_dvs   = dvs_reg;
    assign out_quot  = quot_reg;
    assign out_side  = side_reg;

endmodule

@@ hw/rtl/atr_poly.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atr_poly: denominator of the rational approximation
// Two stages: q^2 in Q1.15, then 1 + 0.28 q^2 in Q1.15.
// ----------------------------------------------------------------------------
module atr_poly (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [atr_pkg::RATIO_WIDTH-1:0] in_quot,
    input  atr_pkg::side_t                  in_side,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [atr_pkg::RATIO_WIDTH-1:0] out_quot,
    output logic [atr_pkg::RATIO_WIDTH-1:0] out_den,
    output atr_pkg::side_t                  out_side
);

    localparam int RW = atr_pkg::RATIO_WIDTH;
    localparam int RF = atr_pkg::RATIO_FRAC;
    localparam int CW = atr_pkg::COEF_WIDTH;

    logic           sq_valid_reg, den_valid_reg;
    logic           sq_ready, den_ready;
    logic [RW-1:0]  sq_quot_reg, sq_reg;
    atr_pkg::side_t sq_side_reg;
    logic [RW-1:0]  den_quot_reg, den_reg;
    atr_pkg::side_t den_side_reg;

    logic [2*RW-1:0]  sq_prod;
    logic [RW+CW-1:0] coef_prod;
    logic [RW-1:0]    sq_next, den_next;

    // q <= 1.0, so q^2 >> 15 fits in 16 bits and 0.28 q^2 stays below 1.0.
    always_comb begin
        sq_prod   = in_quot * in_quot;
        sq_next   = sq_prod[RW+RF-1:RF];
        coef_prod = sq_reg * atr_pkg::COEF_Q15;
        den_next  = (RW'(1) << RF) + RW'(coef_prod[RW+CW-1:RF]);
    end

    assign den_ready = !den_valid_reg || out_ready;
    assign sq_ready  = !sq_valid_reg || den_ready;
    assign in_ready  = sq_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg  <= 1'b0;
            den_valid_reg <= 1'b0;
        end else begin
            if (sq_ready) begin
                sq_valid_reg <= in_valid;
            end
            if (den_ready) begin
                den_valid_reg <= sq_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (sq_ready && in_valid) begin
            sq_quot_reg <= in_quot;
            sq_reg      <= sq_next;
            sq_side_reg <= in_side;
        end
        if (den_ready && sq_valid_reg) begin
            den_quot_reg <= sq_quot_reg;
            den_reg      <= den_next;
            den_side_reg <= sq_side_reg;
        end
    end

    assign out_valid = den_valid_reg;
    assign out_quot  = den_quot_reg;
    assign out_den   = den_reg;
    assign out_side  = den_side_reg;

endmodule

@@ hw/rtl/atr_final.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atr_final: quadrant correction and output register
// Applies the sign of the ratio, the pi/2 and pi offsets and the x-axis
// special cases, and holds the result until it is taken.
// ----------------------------------------------------------------------------
module atr_final #(
    parameter int ANGLE_FRAC_BITS = atr_pkg::ATR_ANGLE_FRAC_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [ANGLE_FRAC_BITS-1:0]          in_mag,
    input  atr_pkg::side_t                      in_side,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [ANGLE_FRAC_BITS+2:0]   out_angle
);

    localparam int AW = ANGLE_FRAC_BITS + 3;
    localparam logic signed [AW-1:0] ANGLE_PI =
        AW'(atr_pkg::pi_fixed(ANGLE_FRAC_BITS));
    localparam logic signed [AW-1:0] ANGLE_HALF_PI =
        AW'(atr_pkg::half_pi_fixed(ANGLE_FRAC_BITS));

    logic                 valid_reg;
    logic signed [AW-1:0] angle_reg;
    logic signed [AW-1:0] mag, signed_mag, angle_next;
    logic                 opposite;

    always_comb begin
        mag        = {3'b000, in_mag};
        opposite   = in_side.y_neg != in_side.x_neg;
        signed_mag = mag;
        angle_next = '0;
        if (in_side.x_zero) begin
            if (in_side.y_neg) begin
                angle_next = -ANGLE_HALF_PI;
            end else if (!in_side.y_zero) begin
                angle_next = ANGLE_HALF_PI;
            end
        end else if (!in_side.swapped) begin
            if (opposite && !in_side.y_zero) begin
                signed_mag = -mag;
            end
            angle_next = signed_mag;
            if (in_side.x_neg) begin
                angle_next = in_side.y_neg ? signed_mag - ANGLE_PI
                                           : signed_mag + ANGLE_PI;
            end
        end else begin
            if (opposite) begin
                signed_mag = -mag;
            end
            angle_next = ANGLE_HALF_PI - signed_mag;
            if (in_side.y_neg) begin
                angle_next = ANGLE_HALF_PI - signed_mag - ANGLE_PI;
            end
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            angle_reg <= angle_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_angle = angle_reg;

endmodule

@@ hw/rtl/atan2_rational_approx.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atan2_rational_approx: pipelined four-quadrant arctangent
// Computes atan2(y, x) in radians as signed fixed point using the rational
// form atan(z) ~ z / (1 + 0.28 z^2) on the ratio smaller/larger magnitude.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake           Payload
// s_        input      s_valid / s_ready   s_y_coord, s_x_coord (signed)
// m_        output     m_valid / m_ready   m_angle (signed, pi = round(pi*2^F))
//
// One transaction enters per clock and one leaves per clock when the output
// side keeps m_ready high. The pipeline is one setup stage, 15 ratio
// division steps, two denominator stages, ANGLE_FRAC_BITS angle division
// steps and the output register.
// Reset is synchronous and active low; it clears only the valid bits.
// Every stage holds its contents while the stage after it is full and
// stalled, and an empty stage still takes data, so bubbles close up under
// back-pressure and s_ready drops only once the whole pipeline is full.
// ----------------------------------------------------------------------------
module atan2_rational_approx #(
    parameter int INPUT_WIDTH     = atr_pkg::ATR_INPUT_WIDTH,
    parameter int ANGLE_FRAC_BITS = atr_pkg::ATR_ANGLE_FRAC_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [INPUT_WIDTH-1:0]     s_y_coord,
    input  logic signed [INPUT_WIDTH-1:0]     s_x_coord,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [ANGLE_FRAC_BITS+2:0] m_angle
);

    localparam int RW        = atr_pkg::RATIO_WIDTH;
    localparam int RATIO_STEPS = atr_pkg::RATIO_FRAC;
    localparam int ANGLE_STEPS = ANGLE_FRAC_BITS;
    localparam int AW        = ANGLE_FRAC_BITS + 3;
    localparam logic signed [AW-1:0] ANGLE_PI =
        AW'(atr_pkg::pi_fixed(ANGLE_FRAC_BITS));

    // Ratio divider chain: min(|y|,|x|) * 2^15 / max(|y|,|x|).
    // Index 0 is the setup stage output, the last index feeds the polynomial.
    logic                   rd_valid [0:RATIO_STEPS];
    logic                   rd_ready [0:RATIO_STEPS];
    logic [INPUT_WIDTH-1:0] rd_rem   [0:RATIO_STEPS];
    logic [INPUT_WIDTH-1:0] rd_dvs   [0:RATIO_STEPS];
    logic [RW-1:0]          rd_quot  [0:RATIO_STEPS];
    atr_pkg::side_t         rd_side  [0:RATIO_STEPS];

    // Angle divider chain: q * 2^F / (1 + 0.28 q^2). q is below the
    // denominator, so the remainder always fits the denominator width.
    logic                       ad_valid [0:ANGLE_STEPS];
    logic                       ad_ready [0:ANGLE_STEPS];
    logic [RW-1:0]              ad_rem   [0:ANGLE_STEPS];
    logic [RW-1:0]              ad_dvs   [0:ANGLE_STEPS];
    logic [ANGLE_FRAC_BITS-1:0] ad_quot  [0:ANGLE_STEPS];
    atr_pkg::side_t             ad_side  [0:ANGLE_STEPS];

    atr_prep #(
        .INPUT_WIDTH (INPUT_WIDTH)
    ) u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_y      (s_y_coord),
        .in_x      (s_x_coord),
        .out_valid (rd_valid[0]),
        .out_ready (rd_ready[0]),
        .out_rem   (rd_rem[0]),
        .out_dvs   (rd_dvs[0]),
        .out_quot  (rd_quot[0]),
        .out_side  (rd_side[0])
    );

    for (genvar i = 0; i < RATIO_STEPS; i++) begin : g_ratio
        atr_div_step #(
            .DW (INPUT_WIDTH),
            .QW (RW)
        ) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (rd_valid[i]),
            .in_ready  (rd_ready[i]),
            .in_rem    (rd_rem[i]),
            .in_dvs    (rd_dvs[i]),
            .in_quot   (rd_quot[i]),
            .in_side   (rd_side[i]),
            .out_valid (rd_valid[i+1]),
            .out_ready (rd_ready[i+1]),
            .out_rem   (rd_rem[i+1]),
            .out_dvs   (rd_dvs[i+1]),
            .out_quot  (rd_quot[i+1]),
            .out_side  (rd_side[i+1])
        );
    end

    // The polynomial stage starts the angle divider with remainder q and an
    // empty quotient.
    atr_poly u_poly (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (rd_valid[RATIO_STEPS]),
        .in_ready  (rd_ready[RATIO_STEPS]),
        .in_quot   (rd_quot[RATIO_STEPS]),
        .in_side   (rd_side[RATIO_STEPS]),
        .out_valid (ad_valid[0]),
        .out_ready (ad_ready[0]),
        .out_quot  (ad_rem[0]),
        .out_den   (ad_dvs[0]),
        .out_side  (ad_side[0])
    );

    assign ad_quot[0] = '0;

    for (genvar j = 0; j < ANGLE_STEPS; j++) begin : g_angle
        atr_div_step #(
            .DW (RW),
            .QW (ANGLE_FRAC_BITS)
        ) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (ad_valid[j]),
            .in_ready  (ad_ready[j]),
            .in_rem    (ad_rem[j]),
            .in_dvs    (ad_dvs[j]),
            .in_quot   (ad_quot[j]),
            .in_side   (ad_side[j]),
            .out_valid (ad_valid[j+1]),
            .out_ready (ad_ready[j+1]),
            .out_rem   (ad_rem[j+1]),
            .out_dvs   (ad_dvs[j+1]),
            .out_quot  (ad_quot[j+1]),
            .out_side  (ad_side[j+1])
        );
    end

    atr_final #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_final (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (ad_valid[ANGLE_STEPS]),
        .in_ready  (ad_ready[ANGLE_STEPS]),
        .in_mag    (ad_quot[ANGLE_STEPS]),
        .in_side   (ad_side[ANGLE_STEPS]),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_angle (m_angle)
    );

    // The result never leaves the range -pi..+pi.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_angle <= ANGLE_PI) && (m_angle >= -ANGLE_PI))
        else $error("angle outside -pi..pi");

    // The input side only stalls when the pipeline is full behind a held result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled while the pipeline can still advance");

    // Reset empties the pipeline.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // Reset also empties the setup stage.
    assert property (@(posedge aclk)
        !aresetn |=> !rd_valid[0])
        else $error("setup stage valid right after reset");

endmodule
